>>> src/vn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector normalize package
// Widths, stage records and the per-stage step functions of the normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int unsigned CompWidth  = 16;
  localparam int unsigned UnitFrac   = 14;
  localparam int unsigned SumWidth   = 2 * CompWidth;
  localparam int unsigned UnitWidth  = UnitFrac + 2;
  localparam int unsigned SqrtSteps  = CompWidth;
  localparam int unsigned DivSteps   = UnitFrac + 1;
  localparam int unsigned BackStages = SqrtSteps + DivSteps;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [UnitFrac:0] UnitOne = (UnitFrac + 1)'(1) << UnitFrac;

  // Entry handed from the front part to the back part.
  typedef struct packed {
    logic [SumWidth-1:0]       sum;
    logic [2:0][CompWidth-1:0] mag;
    logic [2:0]                neg;
    logic                      last;
  } queue_t;

  // Record carried through the root and divider stages.
  typedef struct packed {
    logic [SumWidth-1:0]       sum;
    logic [SumWidth-1:0]       rem;
    logic [SumWidth-1:0]       root;
    logic [CompWidth-1:0]      len;
    logic [2:0][CompWidth-1:0] mag;
    logic [2:0]                neg;
    logic [2:0][CompWidth-1:0] part;
    logic [2:0][UnitFrac:0]    quo;
    logic                      last;
  } stage_t;

  // One step of the digit-by-digit square root; idx selects the bit pair.
  function automatic stage_t sqrt_step(stage_t s, int unsigned idx);
    stage_t              o;
    logic [SumWidth-1:0] b;
    logic [SumWidth:0]   t;
    o = s;
    b = SumWidth'(1) << (2 * idx);
    t = {1'b0, s.root} + {1'b0, b};
    if ({1'b0, s.rem} >= t) begin
      o.rem  = s.rem - t[SumWidth-1:0];
      o.root = (s.root >> 1) + b;
    end else begin
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  // Sets up the restoring division once the root is known.
  function automatic stage_t div_init(stage_t s);
    stage_t o;
    o = s;
    o.len = s.root[CompWidth-1:0];
    for (int l = 0; l < 3; l++) begin
      o.part[l] = s.mag[l] >> 1;
      o.quo[l]  = '0;
    end
    return o;
  endfunction

  // One quotient bit per lane. The first step brings in the magnitude's low
  // bit; the dividend's remaining bits are zero.
  function automatic stage_t div_step(stage_t s, logic first);
    stage_t             o;
    logic [CompWidth:0] t;
    o = s;
    for (int l = 0; l < 3; l++) begin
      t = {s.part[l], first & s.mag[l][0]};
      if (t >= {1'b0, s.len}) begin
        o.part[l] = CompWidth'(t - {1'b0, s.len});
        o.quo[l]  = {s.quo[l][UnitFrac-1:0], 1'b1};
      end else begin
        o.part[l] = t[CompWidth-1:0];
        o.quo[l]  = {s.quo[l][UnitFrac-1:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

>>> src/vn_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector input channel
// Valid/ready channel carrying one vector per item.
// ----------------------------------------------------------------------------
interface vn_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] comp_x;
  logic signed [15:0] comp_y;
  logic signed [15:0] comp_z;
  logic               is_last;

  modport source (output valid, comp_x, comp_y, comp_z, is_last, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, is_last, output ready);
endinterface

>>> src/vn_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector result channel
// Valid/ready channel carrying one normalized result per item.
// ----------------------------------------------------------------------------
interface vn_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] length_squared;
  logic        [15:0] length;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic               zero_vector;
  logic               last_out;

  modport source (output valid, length_squared, length, unit_x, unit_y, unit_z,
                  zero_vector, last_out, input ready);
  modport sink   (input valid, length_squared, length, unit_x, unit_y, unit_z,
                  zero_vector, last_out, output ready);
endinterface

>>> src/vn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector normalize front part
// Takes items, splits sign from magnitude, squares and sums the components.
// ----------------------------------------------------------------------------
module vn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  vn_in_if.sink            in_i,
  output logic             push_o,
  output vn_pkg::queue_t   push_data_o,
  input  logic             push_ready_i
);
  import vn_pkg::*;

  logic                             f1_v_q, f2_v_q;
  logic [2:0][CompWidth-1:0]        f1_mag_q;
  logic [2:0]                       f1_neg_q, f2_neg_q;
  logic                             f1_last_q, f2_last_q;
  logic [2:0][CompWidth-1:0]        f2_mag_q;
  logic [2:0][SumWidth-1:0]         f2_sq_q;
  logic                             f1_rdy, f2_rdy;
  logic [2:0][CompWidth-1:0]        raw;

  assign raw    = {in_i.comp_z, in_i.comp_y, in_i.comp_x};
  assign f2_rdy = !f2_v_q || push_ready_i;
  assign f1_rdy = !f1_v_q || f2_rdy;
  assign in_i.ready = f1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      if (f1_rdy) f1_v_q <= in_i.valid;
      if (f2_rdy) f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_rdy && in_i.valid) begin
      for (int l = 0; l < 3; l++) begin
        f1_neg_q[l] <= raw[l][CompWidth-1];
        f1_mag_q[l] <= raw[l][CompWidth-1] ? CompWidth'(~raw[l] + 1'b1) : raw[l];
      end
      f1_last_q <= in_i.is_last;
    end
    if (f2_rdy && f1_v_q) begin
      for (int l = 0; l < 3; l++) begin
        f2_sq_q[l] <= f1_mag_q[l] * f1_mag_q[l];
      end
      f2_mag_q  <= f1_mag_q;
      f2_neg_q  <= f1_neg_q;
      f2_last_q <= f1_last_q;
    end
  end

  assign push_o           = f2_v_q;
  assign push_data_o.sum  = f2_sq_q[0] + f2_sq_q[1] + f2_sq_q[2];
  assign push_data_o.mag  = f2_mag_q;
  assign push_data_o.neg  = f2_neg_q;
  assign push_data_o.last = f2_last_q;

endmodule

>>> src/vn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector normalize queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module vn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vn_pkg::queue_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output vn_pkg::queue_t pop_data_o,
  input  logic           pop_i
);
  import vn_pkg::*;

  queue_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 do_push, do_pop;

  assign push_ready_o = cnt_q != (QueuePtrW + 1)'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW + 1)'(do_push) - (QueuePtrW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

>>> src/vn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector normalize back part
// Pipelined square root, pipelined three-lane divider and result register.
// ----------------------------------------------------------------------------
module vn_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  vn_pkg::queue_t pop_data_i,
  output logic           pop_o,
  vn_out_if.source       out_o
);
  import vn_pkg::*;

  stage_t                 st_q [BackStages];
  logic [BackStages-1:0]  v_q;
  stage_t                 st_d [BackStages];
  stage_t                 head;
  logic                   en;
  logic                   out_v_q;
  logic                   is_zero;
  logic [2:0][UnitFrac:0] clamped;
  logic [2:0][UnitWidth-1:0] unit;

  // The whole back pipeline moves together whenever the result register frees.
  assign en    = !out_v_q || out_o.ready;
  assign pop_o = en;

  always_comb begin
    head      = '0;
    head.sum  = pop_data_i.sum;
    head.rem  = pop_data_i.sum;
    head.mag  = pop_data_i.mag;
    head.neg  = pop_data_i.neg;
    head.last = pop_data_i.last;
  end

  for (genvar k = 0; k < BackStages; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_d[k] = sqrt_step(head, SqrtSteps - 1);
    end else if (k < SqrtSteps) begin : g_root
      assign st_d[k] = sqrt_step(st_q[k-1], SqrtSteps - 1 - k);
    end else if (k == SqrtSteps) begin : g_div_first
      assign st_d[k] = div_step(div_init(st_q[k-1]), 1'b1);
    end else begin : g_div
      assign st_d[k] = div_step(st_q[k-1], 1'b0);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= (k == 0) ? pop_valid_i : v_q[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) st_q[k] <= st_d[k];
    end
  end

  assign is_zero = st_q[BackStages-1].len == '0;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      clamped[l] = (st_q[BackStages-1].quo[l] > UnitOne) ? UnitOne
                                                         : st_q[BackStages-1].quo[l];
      unit[l]    = st_q[BackStages-1].neg[l] ? UnitWidth'(-{1'b0, clamped[l]})
                                             : {1'b0, clamped[l]};
      if (is_zero) unit[l] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v_q[BackStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_o.length_squared <= st_q[BackStages-1].sum;
      out_o.length         <= st_q[BackStages-1].len;
      out_o.unit_x         <= unit[0];
      out_o.unit_y         <= unit[1];
      out_o.unit_z         <= unit[2];
      out_o.zero_vector    <= is_zero;
      out_o.last_out       <= st_q[BackStages-1].last;
    end
  end

  assign out_o.valid = out_v_q;

endmodule

>>> src/vector3_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-component vector normalizer
// Squared length, floor square root and per-component unit values of a
// signed Q8.8 vector, one vector per item.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   in_i     sink       comp_x, comp_y, comp_z (signed Q8.8), is_last
//   out_o    source     length_squared, length, unit_x/y/z, zero_vector,
//                       last_out
//
// One item is taken per clock cycle while the input is ready. An item passes
// through 35 registers: two front stages (magnitude, squares), one queue
// entry, sixteen root stages (one bit pair each), fifteen divider stages (one
// quotient bit per lane each) and the result register.
// Reset clears only valid bits and queue pointers; no sweep is needed.
// A stalled output holds the back pipeline, while the front keeps filling the
// four-entry queue, so the input stays ready for several more items.
module vector3_normalize (
  input  logic   clk_i,
  input  logic   rst_ni,
  vn_in_if.sink  in_i,
  vn_out_if.source out_o
);
  import vn_pkg::*;

  logic   push, push_ready, pop, pop_valid;
  queue_t push_data, pop_data;

  // Front part: sign split and sum of squares.
  vn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // Decoupling queue so that each side may stall on its own.
  vn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  // Back part: root, division and result register.
  vn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector normalizer testbench
// Drives vectors into the normalizer, predicts squared length, root and unit
// components for each accepted item, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import vn_pkg::*;

  typedef struct {
    logic [31:0] length_squared;
    logic [15:0] length;
    logic [15:0] unit_x;
    logic [15:0] unit_y;
    logic [15:0] unit_z;
    logic        zero_vector;
    logic        last_out;
  } norm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vn_in_if  vec_ch ();
  vn_out_if res_ch ();

  vector3_normalize u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (vec_ch.sink),
    .out_o  (res_ch.source)
  );

  always #6 clk_i = ~clk_i;

  norm_result_t pending_norms[$];
  int           error_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_off_cycles = 0;

  initial begin
    vec_ch.valid   = 1'b0;
    vec_ch.comp_x  = '0;
    vec_ch.comp_y  = '0;
    vec_ch.comp_z  = '0;
    vec_ch.is_last = 1'b0;
    res_ch.ready   = 1'b0;
  end

  // Floor square root, one bit at a time from the top.
  function automatic logic [15:0] floor_root(logic [31:0] v);
    logic [16:0] r;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      r[b] = 1'b1;
      if (r * r > {32'b0, v}) r[b] = 1'b0;
    end
    return r[15:0];
  endfunction

  function automatic logic [15:0] unit_of(logic signed [15:0] c, logic [15:0] len);
    logic [31:0] mag;
    logic [31:0] q;
    mag = (c < 0) ? 32'(-33'(c)) : 32'(c);
    if (len == 0) return '0;
    q = (mag << UnitFrac) / len;
    if (q > (32'd1 << UnitFrac)) q = 32'd1 << UnitFrac;
    return (c < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic norm_result_t normalize(logic signed [15:0] x, logic signed [15:0] y,
                                             logic signed [15:0] z, logic last);
    norm_result_t r;
    longint       xl, yl, zl, sl;
    logic [31:0]  s;
    xl = x;
    yl = y;
    zl = z;
    sl = xl * xl + yl * yl + zl * zl;
    s  = sl[31:0];
    r.length_squared = s;
    r.length         = floor_root(s);
    r.zero_vector    = (r.length == 0);
    r.unit_x         = unit_of(x, r.length);
    r.unit_y         = unit_of(y, r.length);
    r.unit_z         = unit_of(z, r.length);
    r.last_out       = last;
    return r;
  endfunction

  // Offers one vector, with random idle cycles first, and waits for acceptance.
  // Valid stays high after acceptance; the drain wait, or idle cycles in the next call, lower it.
  task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      vec_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    vec_ch.valid   <= 1'b1;
    vec_ch.comp_x  <= x;
    vec_ch.comp_y  <= y;
    vec_ch.comp_z  <= z;
    vec_ch.is_last <= last;
    @(posedge clk_i);
    while (!vec_ch.ready) @(posedge clk_i);
    pending_norms.push_back(normalize(x, y, z, last));
  endtask

  // Receiver side: random stalls plus an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      res_ch.ready    <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    norm_result_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_norms.size() == 0) begin
        $display("%0t: result with none expected, actual len2=%h", $time,
                 res_ch.length_squared);
        error_count++;
      end else begin
        e = pending_norms.pop_front();
        if (res_ch.length_squared !== e.length_squared || res_ch.length !== e.length ||
            res_ch.unit_x !== e.unit_x || res_ch.unit_y !== e.unit_y ||
            res_ch.unit_z !== e.unit_z || res_ch.zero_vector !== e.zero_vector ||
            res_ch.last_out !== e.last_out) begin
          $display("%0t: mismatch expected %h %h %h %h %h %b %b actual %h %h %h %h %h %b %b",
                   $time, e.length_squared, e.length, e.unit_x, e.unit_y, e.unit_z,
                   e.zero_vector, e.last_out, res_ch.length_squared, res_ch.length,
                   res_ch.unit_x, res_ch.unit_y, res_ch.unit_z, res_ch.zero_vector,
                   res_ch.last_out);
          error_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    vec_ch.valid <= 1'b0;
    while (pending_norms.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    logic [15:0] edges[6] = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0100};
    send_vector(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_vector(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_vector(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send_vector(16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_vector(16'h0000, 16'h7fff, 16'h0000, 1'b0);
    send_vector(16'h0000, 16'h0000, 16'hffff, 1'b0);
    send_vector(16'h0001, 16'h0001, 16'h0001, 1'b0);
    for (int i = 0; i < 12; i++)
      send_vector(edges[$urandom_range(5)], edges[$urandom_range(5)],
                  edges[$urandom_range(5)], i[0]);
  endtask

  // Half small vectors so the quotient bits all get exercised, half full range.
  task automatic test_random(int n);
    logic [15:0] v[3];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(3))
          0:       v[k] = 16'($signed(5'($urandom)));
          1:       v[k] = 16'($signed(10'($urandom)));
          default: v[k] = 16'($urandom);
        endcase
      end
      send_vector(v[0], v[1], v[2], ($urandom_range(7) == 0));
    end
  endtask

  // Receiver holds off long enough that the queue fills and the input stalls.
  task automatic test_backpressure();
    hold_off_cycles = 80;
    test_random(60);
    wait_drained();
    test_random(10);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    send_idle_pct = 23;
    recv_idle_pct = 87;
    test_random(250);
    send_idle_pct = 87;
    recv_idle_pct = 23;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(330);
    test_backpressure();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
